// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcs checker: property failed");

// Consequent must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcs checker: property failed");

`endif

// ===== design/lcs_pkg.sv =====
package lcs_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RES_W   = 9;

  // Operation codes carried on the input channel.
  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_TARGET = 2'd0,
    OP_PUSH_SECOND = 2'd1,
    OP_COMPUTE     = 2'd2
  } opcode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CELL,
    S_DONE
  } state_e;

endpackage

// ===== design/lcs_cell.sv =====
// One cell update of the rolling-row LCS recurrence.
module lcs_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned LEN_W      = 9
) (
  input  logic [VALUE_BITS-1:0] t_val_i,
  input  logic [VALUE_BITS-1:0] s_val_i,
  input  logic [LEN_W-1:0]      diag_i,
  input  logic [LEN_W-1:0]      left_i,
  input  logic [LEN_W-1:0]      above_i,
  output logic [LEN_W-1:0]      len_o
);

  // A match extends the diagonal; otherwise take the longer neighbor.
  always_comb begin
    if (t_val_i == s_val_i) begin
      len_o = diag_i + LEN_W'(1);
    end else if (left_i > above_i) begin
      len_o = left_i;
    end else begin
      len_o = above_i;
    end
  end

endmodule

// ===== design/lcs_min_insertions.sv =====
// Longest-common-subsequence engine with a single rolling row.
// Input channel (in_valid_i / in_ready_o) carries opcode_i and value_i. Opcode
// push-target and push-second append value_i to the matching store, one
// transfer per cycle; a push onto a full store is dropped and sets the overflow
// flag. Opcode compute runs the table and returns one result transfer on the
// output channel (out_valid_o / out_ready_i) with common_length_o,
// min_operations_o and overflow_o, then empties both stores. The unused opcode
// is taken and ignored.
// The compute walks one table row per target element and one cell per second
// element, and skips the walk when either store is empty. Each row first
// fetches its target element and then updates its cells in order, set by the
// single read port of the row memory. The input channel is closed while a
// compute runs; pushes are taken while a result waits.
// A stalled result holds in the output register; a finished compute waits for
// that register to drain. Reset empties both stores and clears the flag; the
// row memory needs no clearing pass since the first row ignores its contents.
module lcs_min_insertions #(
  parameter int unsigned MAX_TARGET = 256,
  parameter int unsigned MAX_SECOND = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lcs_pkg::OPC_W-1:0]         opcode_i,
  input  logic signed [lcs_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lcs_pkg::RES_W-1:0]         min_operations_o,
  output logic [lcs_pkg::RES_W-1:0]         common_length_o,
  output logic                              overflow_o
);

  localparam int unsigned TCW = $clog2(MAX_TARGET + 1);
  localparam int unsigned SCW = $clog2(MAX_SECOND + 1);
  localparam int unsigned TAW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned SAW = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
  localparam int unsigned LW  = SCW;
  localparam int unsigned DW  = (TCW > SCW) ? TCW : SCW;

  lcs_pkg::state_e state_q, state_d;

  logic [TCW-1:0] tcount_q;
  logic [SCW-1:0] scount_q;
  logic           ovf_q;
  logic [TCW-1:0] i_q;
  logic [SCW-1:0] j_q;
  logic [LW-1:0]  left_q, diag_q, lcs_q;

  logic [VALUE_BITS-1:0] tgt_mem [MAX_TARGET];
  logic [VALUE_BITS-1:0] sec_mem [MAX_SECOND];
  logic [LW-1:0]         row_mem [MAX_SECOND+1];
  logic [VALUE_BITS-1:0] tgt_rd_q, sec_rd_q;
  logic [LW-1:0]         row_rd_q;

  logic                     out_valid_q;
  logic [lcs_pkg::RES_W-1:0] min_ops_q, common_q;
  logic                     ovf_out_q;

  logic                  in_xfer, out_free, empty_job, row_end, last_row;
  logic [VALUE_BITS-1:0] elem;
  logic [LW-1:0]         above, new_len;
  logic                  tgt_re, sec_re, row_re, row_we, emit;
  logic [SAW-1:0]        sec_raddr;
  logic [SCW-1:0]        row_raddr;

  // Handshake and job conditions.
  assign in_ready_o = (state_q == lcs_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign empty_job  = (tcount_q == '0) || (scount_q == '0);
  assign row_end    = (j_q == scount_q);
  assign last_row   = ((i_q + TCW'(1)) == tcount_q);
  assign elem       = VALUE_BITS'(value_i);

  // The first row sees zeros above, so the row memory is never cleared.
  assign above = (i_q == '0) ? '0 : row_rd_q;

  lcs_cell #(
    .VALUE_BITS(VALUE_BITS),
    .LEN_W     (LW)
  ) u_cell (
    .t_val_i(tgt_rd_q),
    .s_val_i(sec_rd_q),
    .diag_i (diag_q),
    .left_i (left_q),
    .above_i(above),
    .len_o  (new_len)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcs_pkg::S_IDLE: begin
        if (in_xfer && (opcode_i == lcs_pkg::OP_COMPUTE)) begin
          state_d = empty_job ? lcs_pkg::S_DONE : lcs_pkg::S_LOAD;
        end
      end
      lcs_pkg::S_LOAD: state_d = lcs_pkg::S_CELL;
      lcs_pkg::S_CELL: begin
        if (row_end) begin
          state_d = last_row ? lcs_pkg::S_DONE : lcs_pkg::S_LOAD;
        end
      end
      lcs_pkg::S_DONE: begin
        if (out_free) begin
          state_d = lcs_pkg::S_IDLE;
        end
      end
      default: state_d = lcs_pkg::S_IDLE;
    endcase
  end

  // Memory strobes and read addresses per state.
  always_comb begin
    tgt_re    = 1'b0;
    sec_re    = 1'b0;
    row_re    = 1'b0;
    row_we    = 1'b0;
    emit      = 1'b0;
    sec_raddr = j_q[SAW-1:0];
    row_raddr = j_q + SCW'(1);
    unique case (state_q)
      lcs_pkg::S_LOAD: begin
        tgt_re    = 1'b1;
        sec_re    = 1'b1;
        row_re    = 1'b1;
        sec_raddr = '0;
        row_raddr = SCW'(1);
      end
      lcs_pkg::S_CELL: begin
        row_we = 1'b1;
        sec_re = !row_end;
        row_re = !row_end;
      end
      lcs_pkg::S_DONE: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Store writes on push transfers.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (opcode_i == lcs_pkg::OP_PUSH_TARGET) &&
        (tcount_q < TCW'(MAX_TARGET))) begin
      tgt_mem[tcount_q[TAW-1:0]] <= elem;
    end
    if (tgt_re) begin
      tgt_rd_q <= tgt_mem[i_q[TAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (opcode_i == lcs_pkg::OP_PUSH_SECOND) &&
        (scount_q < SCW'(MAX_SECOND))) begin
      sec_mem[scount_q[SAW-1:0]] <= elem;
    end
    if (sec_re) begin
      sec_rd_q <= sec_mem[sec_raddr];
    end
  end

  // Rolling row: write cell j while cell j+1 is read.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[j_q] <= new_len;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_raddr];
    end
  end

  // Fill counts and the overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= '0;
      scount_q <= '0;
      ovf_q    <= 1'b0;
    end else if (emit) begin
      tcount_q <= '0;
      scount_q <= '0;
      ovf_q    <= 1'b0;
    end else if (in_xfer) begin
      unique case (opcode_i)
        lcs_pkg::OP_PUSH_TARGET: begin
          if (tcount_q < TCW'(MAX_TARGET)) begin
            tcount_q <= tcount_q + TCW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        lcs_pkg::OP_PUSH_SECOND: begin
          if (scount_q < SCW'(MAX_SECOND)) begin
            scount_q <= scount_q + SCW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Table walk counters and the carried left and diagonal values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      left_q <= '0;
      diag_q <= '0;
      lcs_q  <= '0;
    end else begin
      unique case (state_q)
        lcs_pkg::S_IDLE: begin
          i_q   <= '0;
          lcs_q <= '0;
        end
        lcs_pkg::S_LOAD: begin
          j_q    <= SCW'(1);
          left_q <= '0;
          diag_q <= '0;
        end
        lcs_pkg::S_CELL: begin
          left_q <= new_len;
          diag_q <= above;
          j_q    <= j_q + SCW'(1);
          if (row_end) begin
            if (last_row) begin
              lcs_q <= new_len;
            end else begin
              i_q <= i_q + TCW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      min_ops_q <= lcs_pkg::RES_W'(DW'(tcount_q) - DW'(lcs_q));
      common_q  <= lcs_pkg::RES_W'(lcs_q);
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign min_operations_o = min_ops_q;
  assign common_length_o  = common_q;
  assign overflow_o       = ovf_out_q;

endmodule

// ===== design/lcs_chk.sv =====
`include "assert_macros.svh"

// Port-level checks of the LCS engine.
module lcs_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [lcs_pkg::OPC_W-1:0] opcode_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lcs_pkg::RES_W-1:0] common_length_o
);

  logic compute_xfer, push_xfer;

  assign compute_xfer = in_valid_i && in_ready_o && (opcode_i == lcs_pkg::OP_COMPUTE);
  assign push_xfer    = in_valid_i && in_ready_o &&
                        ((opcode_i == lcs_pkg::OP_PUSH_TARGET) ||
                         (opcode_i == lcs_pkg::OP_PUSH_SECOND));

  // A stalled result stays put.
  `LCS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(common_length_o))

  // The input closes while a compute runs.
  `LCS_ASSERT_NEXT(a_busy_after_compute, compute_xfer, !in_ready_o)

  // Pushes never close the input.
  `LCS_ASSERT_NEXT(a_push_keeps_ready, push_xfer, in_ready_o)

endmodule

bind lcs_min_insertions lcs_chk u_lcs_chk (.*);
